/* hdl/markdown_to_ansi_stream_styler_defines.svh */
// ----------------------------------------------------------------------------
// markdown_to_ansi_stream_styler_defines
// Assertion macros shared by the styler RTL.
// ----------------------------------------------------------------------------
`ifndef MARKDOWN_TO_ANSI_STREAM_STYLER_DEFINES_SVH
`define MARKDOWN_TO_ANSI_STREAM_STYLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MDANSI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("styler assertion failed");

// Next-cycle implication, checked outside reset.
`define MDANSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("styler assertion failed");

`endif

/* hdl/mdansi_pkg.sv */
// ----------------------------------------------------------------------------
// mdansi_pkg
// Types, character codes and escape string tables for the styler.
// ----------------------------------------------------------------------------
package mdansi_pkg;

   localparam int WIN_DEPTH = 4;
   localparam int NUM_SLOTS = 9;

   // Output pieces, emitted in ascending slot order within one segment.
   typedef logic [3:0] slot_type;
   localparam slot_type SLOT_RESET   = 4'd0;
   localparam slot_type SLOT_CYAN    = 4'd1;
   localparam slot_type SLOT_MAG     = 4'd2;
   localparam slot_type SLOT_BOLDON  = 4'd3;
   localparam slot_type SLOT_BOLDOFF = 4'd4;
   localparam slot_type SLOT_HEAD    = 4'd5;
   localparam slot_type SLOT_HMARK   = 4'd6;
   localparam slot_type SLOT_BULLET  = 4'd7;
   localparam slot_type SLOT_RAW     = 4'd8;

   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_DASH   = 8'h2d;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_RBRACK = 8'h5d;
   localparam logic [7:0] CH_BTICK  = 8'h60;

   localparam logic [7:0] STR_RESET [4]   = '{8'h1b, 8'h5b, 8'h30, 8'h6d};
   localparam logic [7:0] STR_CYAN [5]    = '{8'h1b, 8'h5b, 8'h33, 8'h36, 8'h6d};
   localparam logic [7:0] STR_MAG [5]     = '{8'h1b, 8'h5b, 8'h33, 8'h35, 8'h6d};
   localparam logic [7:0] STR_BOLDON [4]  = '{8'h1b, 8'h5b, 8'h31, 8'h6d};
   localparam logic [7:0] STR_BOLDOFF [5] = '{8'h1b, 8'h5b, 8'h32, 8'h32, 8'h6d};
   localparam logic [7:0] STR_HEAD [8]    = '{8'h1b, 8'h5b, 8'h31, 8'h3b,
                                              8'h39, 8'h36, 8'h6d, 8'h00};
   // ESC[33m, U+2022 as UTF-8, space, ESC[0m
   localparam logic [7:0] STR_BULLET [16] = '{8'h1b, 8'h5b, 8'h33, 8'h33,
                                              8'h6d, 8'he2, 8'h80, 8'ha2,
                                              8'h20, 8'h1b, 8'h5b, 8'h30,
                                              8'h6d, 8'h00, 8'h00, 8'h00};

   // One consume step's output: a set of pieces plus their payload.
   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [7:0]           raw;
      logic [1:0]           hlevel;
      logic                 last;
   } seg_type;

   typedef struct packed {
      logic [2:0] count;
      logic       eos_busy;
   } eng_status_type;

   function automatic logic [3:0] piece_len(input slot_type slot,
                                            input logic [1:0] hlevel);
      logic [3:0] len;
      case (slot)
         SLOT_RESET:   len = 4'd4;
         SLOT_CYAN:    len = 4'd5;
         SLOT_MAG:     len = 4'd5;
         SLOT_BOLDON:  len = 4'd4;
         SLOT_BOLDOFF: len = 4'd5;
         SLOT_HEAD:    len = 4'd7;
         SLOT_HMARK:   len = {2'b00, hlevel} + 4'd1;
         SLOT_BULLET:  len = 4'd13;
         SLOT_RAW:     len = 4'd1;
         default:      len = 4'd1;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] piece_byte(input slot_type slot,
                                             input logic [3:0] pos,
                                             input logic [1:0] hlevel,
                                             input logic [7:0] raw);
      logic [7:0] b;
      case (slot)
         SLOT_RESET:   b = STR_RESET[pos[1:0]];
         SLOT_CYAN:    b = (pos < 4'd5) ? STR_CYAN[3'(pos)] : 8'h00;
         SLOT_MAG:     b = (pos < 4'd5) ? STR_MAG[3'(pos)] : 8'h00;
         SLOT_BOLDON:  b = STR_BOLDON[pos[1:0]];
         SLOT_BOLDOFF: b = (pos < 4'd5) ? STR_BOLDOFF[3'(pos)] : 8'h00;
         SLOT_HEAD:    b = STR_HEAD[pos[2:0]];
         SLOT_HMARK:   b = (pos < {2'b00, hlevel}) ? CH_HASH : CH_SPACE;
         SLOT_BULLET:  b = STR_BULLET[pos];
         SLOT_RAW:     b = raw;
         default:      b = raw;
      endcase
      return b;
   endfunction

endpackage

/* hdl/mdansi_engine.sv */
// ----------------------------------------------------------------------------
// mdansi_engine
// Input register, lookahead window, style flags and token match.
// ----------------------------------------------------------------------------
module mdansi_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  logic [7:0]                  req_text_byte,
   output logic                        seg_valid,
   input  logic                        seg_ready,
   output mdansi_pkg::seg_type         seg,
   output mdansi_pkg::eng_status_type  status
);
   import mdansi_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff;
   logic [7:0] in_byte_ff;

   logic [7:0] win_ff [WIN_DEPTH];
   logic [2:0] count_ff, count_in;
   logic       code_ff, code_in;
   logic       mblock_ff, mblock_in;
   logic       minl_ff, minl_in;
   logic       bold_ff, bold_in;
   logic       icode_ff, icode_in;
   logic       sol_ff, sol_in;

   logic [7:0] view [WIN_DEPTH];
   logic [7:0] shifted [WIN_DEPTH];
   logic [2:0] rem;
   logic [2:0] k;
   logic [2:0] idx;
   logic       fill_only;
   logic       do_consume;
   logic       step;
   logic       item_done;
   logic       r1, r2, r3, r4;
   logic       t_code, t_mblock, t_minl2, t_bold;
   logic       t_h3, t_h2, t_h1, t_bullet, t_btick, t_dollar;

   // A text byte that fills the window is matched with all four bytes.
   always_comb begin
      view = win_ff;
      rem  = count_ff;
      if (!in_kind_ff) begin
         view[3] = in_byte_ff;
         rem     = 3'd4;
      end
   end

   always_comb begin
      r1 = rem >= 3'd1;
      r2 = rem >= 3'd2;
      r3 = rem >= 3'd3;
      r4 = rem >= 3'd4;
      t_code   = r3 && view[0] == CH_BTICK && view[1] == CH_BTICK && view[2] == CH_BTICK;
      t_mblock = r2 && ((view[0] == CH_DOLLAR && view[1] == CH_DOLLAR) ||
                        (view[0] == CH_BSLASH && view[1] == CH_LBRACK) ||
                        (view[0] == CH_BSLASH && view[1] == CH_RBRACK));
      t_minl2  = r2 && view[0] == CH_BSLASH &&
                 (view[1] == CH_LPAREN || view[1] == CH_RPAREN);
      t_bold   = r2 && view[0] == CH_STAR && view[1] == CH_STAR;
      t_h3     = sol_ff && r4 && view[0] == CH_HASH && view[1] == CH_HASH &&
                 view[2] == CH_HASH && view[3] == CH_SPACE;
      t_h2     = sol_ff && r3 && view[0] == CH_HASH && view[1] == CH_HASH &&
                 view[2] == CH_SPACE;
      t_h1     = sol_ff && r2 && view[0] == CH_HASH && view[1] == CH_SPACE;
      t_bullet = sol_ff && r2 && (view[0] == CH_DASH || view[0] == CH_STAR) &&
                 view[1] == CH_SPACE;
      t_btick  = r1 && view[0] == CH_BTICK;
      t_dollar = r1 && view[0] == CH_DOLLAR;
   end

   // Consume one token or one raw byte at the window front.
   always_comb begin
      code_in   = code_ff;
      mblock_in = mblock_ff;
      minl_in   = minl_ff;
      bold_in   = bold_ff;
      icode_in  = icode_ff;
      sol_in    = 1'b0;
      k         = 3'd1;
      seg       = '0;
      seg.raw   = view[0];
      if (t_code) begin
         code_in = !code_ff;
         seg.mask[code_in ? SLOT_CYAN : SLOT_RESET] = 1'b1;
         k = 3'd3;
      end else if (t_mblock) begin
         mblock_in = !mblock_ff;
         seg.mask[mblock_in ? SLOT_MAG : SLOT_RESET] = 1'b1;
         k = 3'd2;
      end else if (t_minl2) begin
         minl_in = !minl_ff;
         seg.mask[minl_in ? SLOT_MAG : SLOT_RESET] = 1'b1;
         k = 3'd2;
      end else if (t_bold) begin
         bold_in = !bold_ff;
         seg.mask[bold_in ? SLOT_BOLDON : SLOT_BOLDOFF] = 1'b1;
         k = 3'd2;
      end else if (t_h3 || t_h2 || t_h1) begin
         seg.mask[SLOT_HEAD]  = 1'b1;
         seg.mask[SLOT_HMARK] = 1'b1;
         seg.hlevel = t_h3 ? 2'd3 : (t_h2 ? 2'd2 : 2'd1);
         k = t_h3 ? 3'd4 : (t_h2 ? 3'd3 : 3'd2);
      end else if (t_bullet) begin
         seg.mask[SLOT_BULLET] = 1'b1;
         k = 3'd2;
      end else if (t_btick) begin
         icode_in = !icode_ff;
         seg.mask[icode_in ? SLOT_CYAN : SLOT_RESET] = 1'b1;
      end else if (t_dollar) begin
         minl_in = !minl_ff;
         seg.mask[minl_in ? SLOT_MAG : SLOT_RESET] = 1'b1;
      end else begin
         seg.mask[SLOT_RAW] = 1'b1;
         if (view[0] == CH_NL) begin
            // newline restores the block styles and bold after a reset
            sol_in = 1'b1;
            seg.mask[SLOT_RESET]  = 1'b1;
            seg.mask[SLOT_CYAN]   = code_ff;
            seg.mask[SLOT_MAG]    = mblock_ff;
            seg.mask[SLOT_BOLDON] = bold_ff;
         end
      end
      // end of stream with an empty window: closing reset only
      if (in_kind_ff && count_ff == 3'd0) begin
         seg.mask             = '0;
         seg.mask[SLOT_RESET] = 1'b1;
      end
      seg.last = !in_kind_ff || count_ff == 3'd0;
   end

   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         idx = 3'(i) + k;
         shifted[i] = (idx < 3'd4) ? view[idx[1:0]] : 8'h00;
      end
   end

   assign fill_only  = !in_kind_ff && count_ff < 3'd3;
   assign seg_valid  = in_valid_ff && !fill_only;
   assign step       = in_valid_ff && (fill_only || seg_ready);
   assign do_consume = step && !fill_only && !(in_kind_ff && count_ff == 3'd0);
   assign item_done  = step && (!in_kind_ff || count_ff == 3'd0);
   assign req_stall  = in_valid_ff && !item_done;
   assign count_in   = do_consume ? rem - k : count_ff + 3'd1;

   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !item_done);

   assign status.count    = count_ff;
   assign status.eos_busy = in_valid_ff && in_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= 3'd0;
         code_ff     <= 1'b0;
         mblock_ff   <= 1'b0;
         minl_ff     <= 1'b0;
         bold_ff     <= 1'b0;
         icode_ff    <= 1'b0;
         sol_ff      <= 1'b1;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= in_valid_in;
         end
         if (step && fill_only) begin
            count_ff <= count_in;
         end else if (do_consume) begin
            count_ff  <= count_in;
            code_ff   <= code_in;
            mblock_ff <= mblock_in;
            minl_ff   <= minl_in;
            bold_ff   <= bold_in;
            icode_ff  <= icode_in;
            sol_ff    <= sol_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_text_byte;
      end
      if (step && fill_only) begin
         win_ff[count_ff[1:0]] <= in_byte_ff;
      end else if (do_consume) begin
         win_ff <= shifted;
      end
   end

endmodule

/* hdl/mdansi_emitter.sv */
// ----------------------------------------------------------------------------
// mdansi_emitter
// Serializes one segment into bytes through the result register.
// ----------------------------------------------------------------------------
module mdansi_emitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 seg_valid,
   output logic                 seg_ready,
   input  mdansi_pkg::seg_type  seg,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last
);
   import mdansi_pkg::*;

   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   logic [7:0]           raw_ff;
   logic [1:0]           hlevel_ff;
   logic                 last_ff;
   logic [3:0]           pos_ff, pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff;
   logic                 rsp_last_ff;

   slot_type             slot;
   logic [NUM_SLOTS-1:0] rest;
   logic                 active;
   logic                 adv;
   logic                 str_end;
   logic                 seg_end;
   logic                 load;
   logic [7:0]           cur_byte;

   // lowest pending piece goes first
   always_comb begin
      slot = SLOT_RAW;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            slot = slot_type'(i);
         end
      end
   end

   assign rest     = mask_ff & ~(NUM_SLOTS'(1) << slot);
   assign active   = mask_ff != '0;
   assign adv      = active && (!rsp_valid_ff || !rsp_stall);
   assign str_end  = pos_ff == piece_len(slot, hlevel_ff) - 4'd1;
   assign seg_end  = adv && str_end && rest == '0;
   assign seg_ready = !active || seg_end;
   assign load     = seg_valid && seg_ready;
   assign cur_byte = piece_byte(slot, pos_ff, hlevel_ff, raw_ff);

   always_comb begin
      mask_in = mask_ff;
      pos_in  = pos_ff;
      if (adv) begin
         pos_in = str_end ? 4'd0 : pos_ff + 4'd1;
         if (str_end) begin
            mask_in = rest;
         end
      end
      if (load) begin
         mask_in = seg.mask;
         pos_in  = 4'd0;
      end
   end

   assign rsp_valid_in = adv || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         pos_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         raw_ff    <= seg.raw;
         hlevel_ff <= seg.hlevel;
         last_ff   <= seg.last;
      end
      if (adv) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= last_ff && str_end && rest == '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

/* hdl/markdown_to_ansi_stream_styler.sv */
// ----------------------------------------------------------------------------
// markdown_to_ansi_stream_styler
// Restyles a markdown text byte stream into ANSI terminal text.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per text byte (req_kind = 0) or an end-of-stream
//            marker (req_kind = 1). Accepted when req_valid && !req_stall.
//   rsp_*  : one result per output byte; rsp_last marks the final byte of
//            a request. Taken when rsp_valid && !rsp_stall.
//   A text request that leaves fewer than four bytes buffered yields no
//   bytes. Once four are held, one token is matched and consumed.
// The first output byte passes the input, piece and output registers.
// Throughput: one request per cycle while each request yields one byte and
//   rsp_stall is low; a request yielding N bytes occupies the serializer.
//   End of stream needs one match per token held (at most 3) plus one for
//   the closing reset, each handed over once the serializer is free.
// Reset clears the buffered count and every style and sets line start.
// A stalled receiver holds the output register; the serializer and then
// the input register back up, and req_stall rises.
// ----------------------------------------------------------------------------
`include "markdown_to_ansi_stream_styler_defines.svh"

module markdown_to_ansi_stream_styler (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);
   import mdansi_pkg::*;

   // segment hand-off: one consumed token's pieces
   seg_type        seg;
   logic           seg_valid;
   logic           seg_ready;
   eng_status_type status;
   logic           hmark_seg;
   logic           eos_close;

   // token matching, window and style state
   mdansi_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_text_byte (req_text_byte),
      .seg_valid     (seg_valid),
      .seg_ready     (seg_ready),
      .seg           (seg),
      .status        (status)
   );

   // piece-by-piece byte serializer with output register
   mdansi_emitter u_emitter (
      .clock        (clock),
      .reset        (reset),
      .seg_valid    (seg_valid),
      .seg_ready    (seg_ready),
      .seg          (seg),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   assign hmark_seg = seg_valid && seg.mask[SLOT_HMARK];
   assign eos_close = status.eos_busy && seg_valid && seg_ready && seg.last;

   // every segment carries at least one piece
   `MDANSI_ASSERT_IMPLY(a_seg_nonempty, clock, reset, seg_valid, seg.mask != '0)
   // window never holds more than three bytes between requests
   `MDANSI_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, status.count <= 3'd3)
   // a heading marker always has a level
   `MDANSI_ASSERT_IMPLY(a_hmark_level, clock, reset, hmark_seg, seg.hlevel != 2'd0)
   // the closing segment of end of stream leaves the window empty
   `MDANSI_ASSERT_NEXT(a_eos_drained, clock, reset, eos_close, status.count == 3'd0)

endmodule
